FILE: rtl/occupancy_frontier_detector_unit_defines.svh
// Assertion macros shared by the frontier detector RTL.
// Depends on nothing; expects aclk and aresetn in the including scope.
`ifndef OCCUPANCY_FRONTIER_DETECTOR_UNIT_DEFINES_SVH
`define OCCUPANCY_FRONTIER_DETECTOR_UNIT_DEFINES_SVH

// Condition must never be true at a clock edge outside reset.
`define OFD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("ofd: forbidden condition seen");

// Antecedent true at an edge implies the consequent at the same edge.
`define OFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ofd: implication failed");

`endif

FILE: rtl/ofd_pkg.sv
// Shared types, constants and functions of the frontier detector.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ofd_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_W      = 8;
    localparam int CELL_W     = 2;
    localparam int WIN_COL_W  = 3 * CELL_W;
    localparam int WIN_W      = 3 * WIN_COL_W;
    localparam int SLOT_N     = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(150);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(150);
    localparam logic [DIM_W-1:0] WIDTH_LIMIT  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = DIM_W'(MAX_HEIGHT);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic signed [7:0] RAW_FREE    = 8'sd0;
    localparam logic signed [7:0] RAW_UNKNOWN = -8'sd1;

    typedef enum logic [CELL_W-1:0] {
        CODE_FREE     = 2'd0,
        CODE_UNKNOWN  = 2'd1,
        CODE_OCCUPIED = 2'd2
    } cell_code_t;

    // One queued item: the window after it was shifted in, its position and
    // the set of centres it completes (bit 0 up-left, 1 up, 2 left, 3 itself).
    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic [COL_W-1:0]  x;
        logic [ROW_W-1:0]  y;
        logic [SLOT_N-1:0] mask;
        logic              left_in;
        logic              top_in;
    } ofd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ofd_qstat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        if (v < DIM_W'(2)) begin
            return DIM_W'(2);
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    // Window column 0 is the oldest, row 0 the top. The centre sits in column
    // 1 or 2 and row 1 or 2; column 0 and row 0 may lie outside the grid.
    function automatic logic frontier(input logic [WIN_W-1:0] win,
                                      input logic cc2, input logic cr2,
                                      input logic left_in, input logic top_in);
        logic             hit;
        logic             col_ok;
        logic             row_ok;
        logic [CELL_W-1:0] nb_code;
        logic [CELL_W-1:0] centre;
        hit    = 1'b0;
        centre = win[((cc2 ? 2 : 1) * 3 + (cr2 ? 2 : 1)) * CELL_W +: CELL_W];
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                col_ok  = (c != 0) || (!cc2 && left_in);
                row_ok  = (r != 0) || (!cr2 && top_in);
                nb_code = win[(c * 3 + r) * CELL_W +: CELL_W];
                if (col_ok && row_ok && (nb_code == CODE_UNKNOWN)) begin
                    hit = 1'b1;
                end
            end
        end
        return (centre == CODE_FREE) && hit;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ofd_front.sv
// Front part: configuration, raster counters, line store and 3x3 window.
// Depends on ofd_pkg; pushes completed windows into the item queue.
`default_nettype none

module ofd_front import ofd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [7:0]    s_cell_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    output logic                      q_push,
    output ofd_entry_t                q_entry,
    input  wire ofd_qstat_t           q_stat
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;
    logic              s1_valid_reg;
    cell_code_t        s1_code_reg;
    logic [COL_W-1:0]  s1_x_reg;
    logic [ROW_W-1:0]  s1_y_reg;
    logic [SLOT_N-1:0] s1_mask_reg;
    logic              s1_left_reg;
    logic              s1_top_reg;
    logic [2*CELL_W-1:0] rd_reg;

    // Each entry holds {row before previous, previous row} for one column.
    logic [2*CELL_W-1:0] line_mem [MAX_WIDTH];

    logic              s_accept;
    logic              adv;
    logic              x_last;
    logic              y_last;
    cell_code_t        code_in;
    logic [SLOT_N-1:0] mask_in;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign adv       = s1_valid_reg && ((s1_mask_reg == '0) || !q_stat.full);
    assign s_ready   = !s1_valid_reg || adv;

    assign x_last = (DIM_W'(col_reg) == (width_reg - DIM_W'(1)));
    assign y_last = (DIM_W'(row_reg) == (height_reg - DIM_W'(1)));

    always_comb begin
        priority if (s_cell_value == RAW_FREE) begin
            code_in = CODE_FREE;
        end else if (s_cell_value == RAW_UNKNOWN) begin
            code_in = CODE_UNKNOWN;
        end else begin
            code_in = CODE_OCCUPIED;
        end
    end

    assign mask_in = {y_last && x_last,
                      y_last && (col_reg != '0),
                      (row_reg != '0) && x_last,
                      (row_reg != '0) && (col_reg != '0)};

    assign win_next = {s1_code_reg, rd_reg[CELL_W-1:0], rd_reg[2*CELL_W-1:CELL_W],
                       win_reg[WIN_W-1:WIN_COL_W]};

    assign q_push  = adv && (s1_mask_reg != '0);
    assign q_entry = '{win: win_next, x: s1_x_reg, y: s1_y_reg, mask: s1_mask_reg,
                       left_in: s1_left_reg, top_in: s1_top_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            win_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            priority if (cfg_valid) begin
                unique case (cfg_index)
                    REG_GRID_WIDTH:  width_reg  <= clamp_dim(cfg_data, WIDTH_LIMIT);
                    REG_GRID_HEIGHT: height_reg <= clamp_dim(cfg_data, HEIGHT_LIMIT);
                endcase
                col_reg <= '0;
                row_reg <= '0;
                win_reg <= '0;
            end else begin
                if (adv) begin
                    win_reg <= win_next;
                end
                if (s_accept) begin
                    if (x_last) begin
                        col_reg <= '0;
                        row_reg <= y_last ? '0 : row_reg + ROW_W'(1);
                    end else begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // The write of a column always lands before the next read of that column,
    // since a row is at least two cells wide.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_code_reg <= code_in;
            s1_x_reg    <= col_reg;
            s1_y_reg    <= row_reg;
            s1_mask_reg <= mask_in;
            s1_left_reg <= (col_reg >= COL_W'(2));
            s1_top_reg  <= (row_reg >= ROW_W'(2));
            rd_reg      <= line_mem[col_reg];
        end
        if (adv) begin
            line_mem[s1_x_reg] <= {rd_reg[CELL_W-1:0], s1_code_reg};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ofd_fifo.sv
// Short queue of completed windows between the front and back parts.
// Depends on ofd_pkg for the entry type and the queue depth.
`default_nettype none

module ofd_fifo import ofd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire ofd_entry_t  push_entry,
    input  wire logic        pop,
    output ofd_entry_t       head,
    output ofd_qstat_t       stat
);

    ofd_entry_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ofd_back.sv
// Back part: walks the centres of the queue head, classifies each one and
// drives the result register. Depends on ofd_pkg.
`default_nettype none

module ofd_back import ofd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ofd_entry_t  head,
    input  wire ofd_qstat_t  q_stat,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [OUT_W-1:0] m_center_x,
    output logic [OUT_W-1:0] m_center_y,
    output logic             m_is_frontier,
    output logic             m_last_of_run
);

    logic [SLOT_N-1:0] done_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_center_x_reg;
    logic [OUT_W-1:0]  m_center_y_reg;
    logic              m_is_frontier_reg;
    logic              m_last_of_run_reg;

    logic [SLOT_N-1:0] pending;
    logic [SLOT_N-1:0] sel;
    logic              last;
    logic              load;
    logic              cc2;
    logic              cr2;

    assign pending = head.mask & ~done_reg;
    assign sel     = pending & (~pending + SLOT_N'(1));
    assign last    = ((pending & ~sel) == '0);
    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign q_pop   = load && last;

    // Centres in window column 2 or row 2 are the current column or row.
    assign cc2 = sel[1] || sel[3];
    assign cr2 = sel[2] || sel[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                done_reg    <= last ? '0 : (done_reg | sel);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_center_x_reg    <= OUT_W'(cc2 ? head.x : head.x - COL_W'(1));
            m_center_y_reg    <= OUT_W'(cr2 ? head.y : head.y - ROW_W'(1));
            m_is_frontier_reg <= frontier(head.win, cc2, cr2, head.left_in, head.top_in);
            m_last_of_run_reg <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_center_x    = m_center_x_reg;
    assign m_center_y    = m_center_y_reg;
    assign m_is_frontier = m_is_frontier_reg;
    assign m_last_of_run = m_last_of_run_reg;

endmodule

`default_nettype wire

FILE: rtl/occupancy_frontier_detector_unit.sv
// Frontier cell detector over a streamed occupancy grid, one cell per
// transaction in raster order. The input side takes a cell every cycle while
// the queue has room, and the result side delivers one result per cycle from
// its output register while m_ready is high and the queue holds work. A row's
// last cell below the top row and each bottom-row cell but the first complete
// two centres and the frame's last cell four. A four-entry queue between the
// two sides absorbs the extra centres at a row end; along the bottom row the
// queue fills and the input side stalls. A result passes from the input stage
// register through the queue to the output register. The line store is a
// single memory with one read and one write port, read when a cell is taken
// and written on the following advance. No clearing pass runs after reset. Any
// configuration write restarts the frame at column 0, row 0.
`default_nettype none

`include "occupancy_frontier_detector_unit_defines.svh"

module occupancy_frontier_detector_unit import ofd_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [7:0]    s_cell_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [OUT_W-1:0]          m_center_x,
    output logic [OUT_W-1:0]          m_center_y,
    output logic                      m_is_frontier,
    output logic                      m_last_of_run,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    logic       q_push;
    logic       q_pop;
    ofd_entry_t q_entry;
    ofd_entry_t q_head;
    ofd_qstat_t q_stat;

    ofd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_push       (q_push),
        .q_entry      (q_entry),
        .q_stat       (q_stat)
    );

    ofd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    ofd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_center_x    (m_center_x),
        .m_center_y    (m_center_y),
        .m_is_frontier (m_is_frontier),
        .m_last_of_run (m_last_of_run)
    );

    `OFD_ASSERT_NEVER(a_queue_no_overflow, q_push && q_stat.full)
    `OFD_ASSERT_NEVER(a_queue_no_underflow, q_pop && q_stat.empty)
    `OFD_ASSERT_IMPLY(a_result_from_queue, $rose(m_valid), !$past(q_stat.empty))

endmodule

`default_nettype wire

FILE: tb/tb_occupancy_frontier_detector_unit.sv
// Testbench for occupancy_frontier_detector_unit: streams occupancy grids of many sizes,
// predicts every classified centre and checks each result transaction in order.
// Depends on ofd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module tb_occupancy_frontier_detector_unit;
    import ofd_pkg::*;

    localparam int RESET_ITEMS   = 153;
    localparam int TALL_ITEMS    = 16;
    localparam int RANDOM_ITEMS  = 30;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic             frontier;
        logic             last_of_run;
    } center_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [7:0]        s_cell_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [OUT_W-1:0]         m_center_x;
    logic [OUT_W-1:0]         m_center_y;
    logic                     m_is_frontier;
    logic                     m_last_of_run;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DIM_W-1:0]         cfg_data;

    // Predicted detector state.
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    cell_code_t               prev_row [MAX_WIDTH];
    cell_code_t               prev_row2 [MAX_WIDTH];
    logic [WIN_W-1:0]         window_codes;
    int                       col_pos;
    int                       row_pos;

    center_result_t           awaited_centers[$];
    int                       center_mismatches = 0;
    logic                     idle_on = 1'b1;

    occupancy_frontier_detector_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_center_x    (m_center_x),
        .m_center_y    (m_center_y),
        .m_is_frontier (m_is_frontier),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int effective_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v < 2) begin
            return 2;
        end
        if (v > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic cell_code_t window_cell(input int c, input int r);
        return cell_code_t'(window_codes[(c * 3 + r) * CELL_W +: CELL_W]);
    endfunction

    // The centre sits at window column cc and row cr; neighbours that fall
    // outside the grid or outside the window are ignored.
    function automatic logic frontier_at(input int cc, input int cr, input int cx,
                                         input int cy, input int w, input int h);
        logic hit;
        int   ax;
        int   ay;
        int   wc;
        int   wr;
        hit = 1'b0;
        if (window_cell(cc, cr) != CODE_FREE) begin
            return 1'b0;
        end
        for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
                ax = cx + dj;
                ay = cy + di;
                wc = cc + dj;
                wr = cr + di;
                if (ax >= 0 && ay >= 0 && ax < w && ay < h &&
                    wc >= 0 && wc <= 2 && wr >= 0 && wr <= 2) begin
                    if (window_cell(wc, wr) == CODE_UNKNOWN) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    task automatic predict_centers(input logic signed [7:0] value);
        center_result_t batch [4];
        cell_code_t     code;
        cell_code_t     above;
        cell_code_t     above2;
        int             w;
        int             h;
        int             x;
        int             y;
        int             n;
        w = effective_dim(width_reg, MAX_WIDTH);
        h = effective_dim(height_reg, MAX_HEIGHT);
        n = 0;
        if (col_pos >= w) begin
            col_pos = 0;
        end
        if (row_pos >= h) begin
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        if (value == RAW_FREE) begin
            code = CODE_FREE;
        end else if (value == RAW_UNKNOWN) begin
            code = CODE_UNKNOWN;
        end else begin
            code = CODE_OCCUPIED;
        end
        above        = prev_row[x];
        above2       = prev_row2[x];
        prev_row2[x] = above;
        prev_row[x]  = code;
        window_codes = {code, above, above2, window_codes[WIN_W-1:WIN_COL_W]};

        if (y >= 1 && x >= 1) begin
            batch[n] = '{8'(x - 1), 8'(y - 1), frontier_at(1, 1, x - 1, y - 1, w, h), 1'b0};
            n++;
        end
        if (y >= 1 && x == w - 1) begin
            batch[n] = '{8'(x), 8'(y - 1), frontier_at(2, 1, x, y - 1, w, h), 1'b0};
            n++;
        end
        if (y == h - 1 && x >= 1) begin
            batch[n] = '{8'(x - 1), 8'(y), frontier_at(1, 2, x - 1, y, w, h), 1'b0};
            n++;
        end
        if (y == h - 1 && x == w - 1) begin
            batch[n] = '{8'(x), 8'(y), frontier_at(2, 2, x, y, w, h), 1'b0};
            n++;
        end
        if (n > 0) begin
            batch[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            awaited_centers = {awaited_centers, batch[i]};
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endtask

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic signed [7:0] random_cell();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                return RAW_FREE;
            end
            4, 5, 6: begin
                return RAW_UNKNOWN;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // Mostly small grids so that whole frames complete; now and then a value
    // that clamps or reaches the largest size.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0: begin
                return DIM_W'($urandom_range(0, 1));
            end
            1: begin
                return DIM_W'($urandom_range(256, 511));
            end
            default: begin
                return DIM_W'($urandom_range(2, 9));
            end
        endcase
    endfunction

    task automatic send_cell(input logic signed [7:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cell_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_centers(value);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (index == REG_GRID_WIDTH) begin
            width_reg = data;
        end else begin
            height_reg = data;
        end
        // Any register write starts a new frame.
        window_codes = '0;
        col_pos      = 0;
        row_pos      = 0;
    endtask

    task automatic configure_grid(input logic set_w, input logic [DIM_W-1:0] w_val,
                                  input logic set_h, input logic [DIM_W-1:0] h_val);
        if (set_w) begin
            put_reg(REG_GRID_WIDTH, w_val);
        end
        if (set_h) begin
            put_reg(REG_GRID_HEIGHT, h_val);
        end
        cfg_valid <= 1'b0;
    endtask

    // Cells that complete no centre may still be in flight once the queue is
    // empty, so hold off for the pipeline depth as well.
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_centers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The first centres of the 150-cell reset rows appear early in row 1.
    task automatic test_reset_geometry();
        idle_on = 1'b1;
        repeat (RESET_ITEMS) send_cell(random_cell());
        settle();
    endtask

    task automatic test_smallest_grid();
        idle_on = 1'b0;
        configure_grid(1'b1, DIM_W'(0), 1'b1, DIM_W'(1));
        send_cell(RAW_FREE);
        send_cell(RAW_UNKNOWN);
        send_cell(RAW_FREE);
        send_cell(RAW_FREE);
        // Second frame right behind the first, across the wrap.
        send_cell(RAW_FREE);
        send_cell(RAW_FREE);
        send_cell(RAW_FREE);
        send_cell(RAW_UNKNOWN);
        settle();
        configure_grid(1'b1, DIM_W'(2), 1'b1, DIM_W'(2));
        send_cell(8'sh7F);
        send_cell(8'sh80);
        send_cell(8'sh01);
        send_cell(RAW_FREE);
        settle();
    endtask

    task automatic test_extreme_values();
        idle_on = 1'b0;
        configure_grid(1'b1, DIM_W'(3), 1'b1, DIM_W'(3));
        send_cell(8'sh80);
        send_cell(RAW_FREE);
        send_cell(8'sh7F);
        send_cell(RAW_FREE);
        send_cell(RAW_UNKNOWN);
        send_cell(RAW_FREE);
        send_cell(8'sh01);
        send_cell(8'shFE);
        send_cell(RAW_FREE);
        settle();
    endtask

    task automatic test_tallest_columns();
        idle_on = 1'b1;
        configure_grid(1'b1, DIM_W'(2), 1'b1, DIM_W'(511));
        repeat (TALL_ITEMS) send_cell(random_cell());
        settle();
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int area;
        int count;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 2) != 0);
            pick    = $urandom_range(0, 2);
            configure_grid(pick != 1, pick_dim(), pick != 0, pick_dim());
            w    = effective_dim(width_reg, MAX_WIDTH);
            h    = effective_dim(height_reg, MAX_HEIGHT);
            area = w * h;
            if (area > 100) begin
                count = $urandom_range(1, 40);
            end else if ($urandom_range(0, 4) == 0) begin
                count = $urandom_range(1, area - 1);
            end else begin
                count = area * $urandom_range(1, 2);
            end
            if (count > RANDOM_ITEMS - sent) begin
                count = RANDOM_ITEMS - sent;
            end
            repeat (count) send_cell(random_cell());
            sent += count;
            settle();
        end
    endtask

    // Result side: random stalls, then compare each transaction with the
    // oldest predicted centre.
    initial begin
        center_result_t got;
        center_result_t want;
        int             stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{m_center_x, m_center_y, m_is_frontier, m_last_of_run};
            if (awaited_centers.size() == 0) begin
                center_mismatches++;
                if (center_mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: x=%0d y=%0d frontier=%0b last=%0b",
                             got.x, got.y, got.frontier, got.last_of_run);
                end
            end else begin
                want = awaited_centers.pop_front();
                if (got.x !== want.x || got.y !== want.y ||
                    got.frontier !== want.frontier ||
                    got.last_of_run !== want.last_of_run) begin
                    center_mismatches++;
                    if (center_mismatches <= MAX_REPORTS) begin
                        $display("result mismatch: expected x=%0d y=%0d frontier=%0b last=%0b",
                                 want.x, want.y, want.frontier, want.last_of_run);
                        $display("                 actual   x=%0d y=%0d frontier=%0b last=%0b",
                                 got.x, got.y, got.frontier, got.last_of_run);
                    end
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cell_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_GRID_WIDTH;
        cfg_data     = '0;
        width_reg    = WIDTH_RESET;
        height_reg   = HEIGHT_RESET;
        window_codes = '0;
        col_pos      = 0;
        row_pos      = 0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            prev_row[i]  = CODE_FREE;
            prev_row2[i] = CODE_FREE;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_geometry();
        test_smallest_grid();
        test_extreme_values();
        test_tallest_columns();
        test_random_frames();
        settle();

        if (center_mismatches == 0 && awaited_centers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ofd_pkg.sv
rtl/ofd_front.sv
rtl/ofd_fifo.sv
rtl/ofd_back.sv
rtl/occupancy_frontier_detector_unit.sv
tb/tb_occupancy_frontier_detector_unit.sv
